### sv/pfpcd_pkg.sv
// Shared constants, codes and beat types of the parity framed prefix code decoder.
package pfpcd_pkg;

  // Longest codeword the matcher holds
  localparam int MAX_CODE_LEN = 10;
  localparam int PC_W         = MAX_CODE_LEN;
  localparam int PLEN_W       = $clog2(MAX_CODE_LEN + 1);
  localparam int IDX_W        = MAX_CODE_LEN + 1;
  localparam int TABLE_DEPTH  = 2 << MAX_CODE_LEN;

  // Framing
  localparam int FRAME_LEN = 9;
  localparam int DATA_BITS = 8;
  localparam int FILL_W    = 4;
  localparam int BITS_W    = $clog2(DATA_BITS + 1);

  // Beat field widths
  localparam int FUNC_W   = 2;
  localparam int NIBBLE_W = 4;
  localparam int CODE_W   = 10;
  localparam int LEN_W    = 4;
  localparam int SYM_W    = 8;
  localparam int CHARS_W  = 16;

  // Item functions
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_DATA  = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [NIBBLE_W-1:0] nibble;
    logic [CODE_W-1:0]   entry_code;
    logic [LEN_W-1:0]    entry_length;
    logic [SYM_W-1:0]    entry_symbol;
  } in_beat_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } out_beat_t;

  // Table entry: valid flag over symbol
  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] symbol;
  } tbl_entry_t;

endpackage

### sv/pfpcd_if.sv
// Valid/ready channel interfaces for input items and decoded symbols.
interface pfpcd_in_if;
  import pfpcd_pkg::*;

  logic     valid;
  logic     ready;
  in_beat_t beat;

  modport source (output valid, output beat, input ready);
  modport sink   (input valid, input beat, output ready);
endinterface

interface pfpcd_out_if;
  import pfpcd_pkg::*;

  logic      valid;
  logic      ready;
  out_beat_t beat;

  modport source (output valid, output beat, input ready);
  modport sink   (input valid, input beat, output ready);
endinterface

### sv/parity_framed_prefix_code_decoder.sv
// Top level of the parity framed prefix code decoder.
//
// Data nibbles (func DATA) are gathered MSB first into 9-bit frames; a frame
// with an odd count of ones passes its first 8 bits, one per step, into a
// prefix-code matcher that looks each grown partial code up in a 2048-entry
// codeword table held in one single-port-read memory. A match yields a symbol
// beat; the final symbol caused by one input item carries last. Load, start
// and data items that close no kept frame are taken without leaving idle. A
// data item that closes a kept frame walks its 8 data bits in turn: each bit
// is dropped (overflow, output limit, or code too long) or looked up (ST_BIT
// issues the table address, then ST_CHK checks the registered read data);
// ST_FLUSH then hands over the final symbol. A stalled output side holds
// ST_CHK and ST_FLUSH. A clear-table item sweeps every table entry, one per
// cycle. The same sweep runs after reset, so in_i.ready stays low until the
// sweep is done. The output register lets the next item be accepted while
// the last symbol still waits to be taken. max_output_chars is to be written
// through cfg_we_i/cfg_data_i while idle; the block does not enforce this.
module parity_framed_prefix_code_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pfpcd_pkg::CHARS_W-1:0] cfg_data_i,
  pfpcd_in_if.sink                      in_i,
  pfpcd_out_if.source                   out_o
);
  import pfpcd_pkg::*;

  // Sequencer states
  localparam logic [2:0] ST_SWEEP = 3'd0;  // clear the table, one entry a cycle
  localparam logic [2:0] ST_IDLE  = 3'd1;  // take items
  localparam logic [2:0] ST_BIT   = 3'd2;  // grow the partial code, issue lookup
  localparam logic [2:0] ST_CHK   = 3'd3;  // check the looked-up entry
  localparam logic [2:0] ST_FLUSH = 3'd4;  // hand over the final symbol with last

  logic [2:0]         state_q;
  logic [IDX_W-1:0]   sweep_cnt_q;
  logic [CHARS_W-1:0] max_chars_q;

  // Framing and matcher state
  logic [FRAME_LEN-1:0] frame_q;
  logic [FILL_W-1:0]    fill_q;
  logic [PC_W-1:0]      pc_q;
  logic [PLEN_W-1:0]    plen_q;
  logic                 ovf_q;
  logic [CHARS_W-1:0]   emitted_q;

  // Data bits of the kept frame, consumed from the top
  logic [DATA_BITS-1:0] data_q;
  logic [BITS_W-1:0]    bits_left_q;

  // One symbol held back until we know whether it is the last one
  logic             pend_valid_q;
  logic [SYM_W-1:0] pend_sym_q;

  // Output register
  logic      out_valid_q;
  out_beat_t out_beat_q;

  // Codeword table
  tbl_entry_t       tbl_mem [TABLE_DEPTH];
  tbl_entry_t       mem_rdata_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  tbl_entry_t       mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;

  // Handshake
  logic in_acc;
  logic out_free;

  // Frame assembly for one nibble
  logic [FRAME_LEN-1:0] frame_n;
  logic [FILL_W-1:0]    fill_n;
  logic                 frame_done;
  logic [FRAME_LEN-1:0] frame_done_bits;
  logic                 frame_kept;

  // Load address
  logic             load_ok;
  logic [IDX_W-1:0] load_idx;
  logic [IDX_W-1:0] load_mask;

  // Matcher step
  logic              match_act;
  logic              code_full;
  logic [PC_W-1:0]   pc_n;
  logic [PLEN_W-1:0] plen_n;
  logic              hit;
  logic              chk_stall;
  logic              bit_advance;
  logic              out_load;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.beat  = out_beat_q;

  // Shift the nibble in MSB first; at most one frame closes per nibble
  always_comb begin
    frame_n         = frame_q;
    fill_n          = fill_q;
    frame_done      = 1'b0;
    frame_done_bits = '0;
    for (int i = NIBBLE_W - 1; i >= 0; i--) begin
      frame_n = {frame_n[FRAME_LEN-2:0], in_i.beat.nibble[i]};
      fill_n  = FILL_W'(fill_n + 1'b1);
      if (fill_n == FILL_W'(FRAME_LEN)) begin
        frame_done      = 1'b1;
        frame_done_bits = frame_n;
        frame_n         = '0;
        fill_n          = '0;
      end
    end
  end

  // Odd parity keeps the frame
  assign frame_kept = frame_done && (^frame_done_bits);

  // Table index is a leading one above the code, so lengths never collide
  assign load_ok   = (in_i.beat.entry_length != '0) &&
                     ((LEN_W + 1)'(in_i.beat.entry_length) <= (LEN_W + 1)'(MAX_CODE_LEN));
  assign load_mask = IDX_W'((IDX_W'(1) << in_i.beat.entry_length) - IDX_W'(1));
  assign load_idx  = (IDX_W'(1) << in_i.beat.entry_length) |
                     (IDX_W'(in_i.beat.entry_code) & load_mask);

  assign match_act = !ovf_q && (emitted_q < max_chars_q);
  assign code_full = (plen_q >= PLEN_W'(MAX_CODE_LEN));
  assign pc_n      = PC_W'({pc_q, data_q[DATA_BITS-1]});
  assign plen_n    = PLEN_W'(plen_q + 1'b1);

  assign hit       = mem_rdata_q.valid;
  assign chk_stall = (state_q == ST_CHK) && hit && pend_valid_q && !out_free;

  // Move past a dropped bit or a checked lookup
  assign bit_advance = ((state_q == ST_BIT) && !(match_act && !code_full)) ||
                       ((state_q == ST_CHK) && !chk_stall);

  assign out_load = ((state_q == ST_CHK) && hit && pend_valid_q && out_free) ||
                    ((state_q == ST_FLUSH) && pend_valid_q && out_free);

  // Memory ports: sweep and loads write, the matcher reads
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = load_idx;
    mem_wdata = '{valid: 1'b1, symbol: in_i.beat.entry_symbol};
    if (state_q == ST_SWEEP) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_cnt_q;
      mem_wdata = '0;
    end else if (in_acc && (in_i.beat.func == FUNC_LOAD) && load_ok) begin
      mem_we = 1'b1;
    end
  end

  assign mem_re    = (state_q == ST_BIT) && match_act && !code_full;
  assign mem_raddr = (IDX_W'(1) << plen_n) | IDX_W'(pc_n);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= tbl_mem[mem_raddr];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      sweep_cnt_q  <= '0;
      max_chars_q  <= '1;
      frame_q      <= '0;
      fill_q       <= '0;
      pc_q         <= '0;
      plen_q       <= '0;
      ovf_q        <= 1'b0;
      emitted_q    <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_chars_q <= cfg_data_i;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_SWEEP: begin
          sweep_cnt_q <= IDX_W'(sweep_cnt_q + 1'b1);
          if (sweep_cnt_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            case (in_i.beat.func)
              FUNC_CLEAR: begin
                sweep_cnt_q <= '0;
                state_q     <= ST_SWEEP;
              end
              FUNC_START: begin
                frame_q   <= '0;
                fill_q    <= '0;
                pc_q      <= '0;
                plen_q    <= '0;
                ovf_q     <= 1'b0;
                emitted_q <= '0;
              end
              FUNC_DATA: begin
                frame_q <= frame_n;
                fill_q  <= fill_n;
                if (frame_kept) begin
                  state_q <= ST_BIT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_BIT: begin
          if (match_act) begin
            if (code_full) begin
              ovf_q  <= 1'b1;
              pc_q   <= '0;
              plen_q <= '0;
            end else begin
              pc_q    <= pc_n;
              plen_q  <= plen_n;
              state_q <= ST_CHK;
            end
          end
        end
        ST_CHK: begin
          if (!chk_stall && hit) begin
            pc_q         <= '0;
            plen_q       <= '0;
            emitted_q    <= CHARS_W'(emitted_q + 1'b1);
            pend_valid_q <= 1'b1;
          end
        end
        ST_FLUSH: begin
          if (!pend_valid_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            pend_valid_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // Step to the next data bit, or finish the frame
      if (bit_advance) begin
        state_q <= (bits_left_q == BITS_W'(1)) ? ST_FLUSH : ST_BIT;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc && (in_i.beat.func == FUNC_DATA) && frame_kept) begin
      data_q      <= frame_done_bits[FRAME_LEN-1:FRAME_LEN-DATA_BITS];
      bits_left_q <= BITS_W'(DATA_BITS);
    end else if (bit_advance) begin
      data_q      <= {data_q[DATA_BITS-2:0], 1'b0};
      bits_left_q <= BITS_W'(bits_left_q - 1'b1);
    end
    if ((state_q == ST_CHK) && !chk_stall && hit) begin
      pend_sym_q <= mem_rdata_q.symbol;
    end
    if (out_load) begin
      out_beat_q.symbol <= pend_sym_q;
      out_beat_q.last   <= (state_q == ST_FLUSH);
    end
  end

endmodule

### sv/pfpcd_checker.sv
// Port-level assertions for the parity framed prefix code decoder, bound to the top level.
module pfpcd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic [pfpcd_pkg::FUNC_W-1:0] in_func_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input pfpcd_pkg::out_beat_t         out_beat_i
);
  import pfpcd_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A clear-table beat starts the table sweep: no beat taken next cycle
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_func_i == FUNC_CLEAR) |=> !in_ready_i)
    else $error("input still ready right after a clear-table beat");

  // Load and start beats finish in their own cycle
  a_quick_items: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && ((in_func_i == FUNC_LOAD) || (in_func_i == FUNC_START)) |=> in_ready_i)
    else $error("input not ready after a load or start beat");

  // Non-data beats never cause a symbol
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_func_i != FUNC_DATA) && !out_valid_i |=> !out_valid_i)
    else $error("symbol appeared after a non-data beat");

  // A stalled symbol beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_beat_i))
    else $error("stalled output beat changed or dropped");

endmodule

bind parity_framed_prefix_code_decoder pfpcd_checker u_pfpcd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_func_i   (in_i.beat.func),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_beat_i  (out_o.beat)
);
